FILE: hw/rtl/mct_pkg.sv
package mct_pkg;

	// bank size and time base
	localparam int unsigned NUM_TIMERS  = 16;
	localparam int unsigned TIME_W      = 32;
	localparam int unsigned MAX_RESULTS = 16;

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_RESULTS + 1);

	// item field widths
	localparam int unsigned OP_W  = 4;
	localparam int unsigned CH_W  = 4;
	localparam int unsigned ACT_W = 8;
	localparam int unsigned PER_W = 32;
	localparam int unsigned REM_W = 32;

	// command codes
	localparam logic [OP_W-1:0] OP_TICK     = OP_W'(0);
	localparam logic [OP_W-1:0] OP_PERIODIC = OP_W'(1);
	localparam logic [OP_W-1:0] OP_IDLE     = OP_W'(2);
	localparam logic [OP_W-1:0] OP_ONCE     = OP_W'(3);
	localparam logic [OP_W-1:0] OP_SEVERAL  = OP_W'(4);
	localparam logic [OP_W-1:0] OP_SET_PER  = OP_W'(5);
	localparam logic [OP_W-1:0] OP_ENABLE   = OP_W'(6);
	localparam logic [OP_W-1:0] OP_DISABLE  = OP_W'(7);
	localparam logic [OP_W-1:0] OP_RESYNC   = OP_W'(8);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PERIODIC,
		MODE_ONCE,
		MODE_SEVERAL
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept_cmd;
		logic accept_tick;
		logic scan_en;
		logic flush;
	} mct_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic fire;
		logic pend_v;
		logic out_free;
		logic idx_last;
	} mct_sts_t;

endpackage

FILE: hw/rtl/mct_dp.sv
module mct_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mct_pkg::mct_cmd_t         cmd,
	output mct_pkg::mct_sts_t         sts,
	input  logic [mct_pkg::OP_W-1:0]  opcode,
	input  logic [mct_pkg::CH_W-1:0]  channel,
	input  logic [mct_pkg::PER_W-1:0] interval,
	input  logic [mct_pkg::PER_W-1:0] offset,
	input  logic [mct_pkg::REM_W-1:0] repeat_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mct_pkg::CH_W-1:0]  fired_channel,
	output logic                      last
);
	import mct_pkg::*;

	logic [TIME_W-1:0] time_q;
	mode_t             mode_q  [NUM_TIMERS];
	logic [ACT_W-1:0]  act_q   [NUM_TIMERS];
	logic [TIME_W-1:0] dl_q    [NUM_TIMERS];
	logic [PER_W-1:0]  per_q   [NUM_TIMERS];
	logic [REM_W-1:0]  rem_q   [NUM_TIMERS];

	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_ch_q;
	logic             out_v_q;
	logic [CH_W-1:0]  out_ch_q;
	logic             out_last_q;

	logic [IDX_W-1:0]  sel;
	mode_t             rd_mode, nx_mode;
	logic [ACT_W-1:0]  rd_act, nx_act;
	logic [TIME_W-1:0] rd_dl, nx_dl;
	logic [PER_W-1:0]  rd_per, nx_per;
	logic [REM_W-1:0]  rd_rem, nx_rem;
	logic              we;
	logic              ch_ok, hit, raise, report, out_free, out_load;
	logic [ACT_W-1:0]  act_bump;

	assign ch_ok = 32'(channel) < NUM_TIMERS;
	assign sel   = cmd.accept_cmd ? IDX_W'(channel) : idx_q;

	assign rd_mode = mode_q[sel];
	assign rd_act  = act_q[sel];
	assign rd_dl   = dl_q[sel];
	assign rd_per  = per_q[sel];
	assign rd_rem  = rem_q[sel];

	assign hit      = time_q > rd_dl;
	assign raise    = hit && (rd_act != '0);
	assign report   = raise && (cnt_q < CNT_W'(MAX_RESULTS));
	assign act_bump = (rd_act == '1) ? rd_act : rd_act + 1'b1;
	assign out_free = !out_v_q || out_ready;

	// next value of the one entry touched this cycle
	always_comb begin
		nx_mode = rd_mode;
		nx_act  = rd_act;
		nx_dl   = rd_dl;
		nx_per  = rd_per;
		nx_rem  = rd_rem;
		we      = 1'b0;
		if (cmd.accept_cmd && ch_ok) begin
			we = 1'b1;
			case (opcode)
				OP_PERIODIC: begin
					nx_mode = MODE_PERIODIC;
					nx_per  = interval;
					nx_dl   = time_q + TIME_W'(offset);
					nx_act  = ACT_W'(1);
				end
				OP_IDLE: begin
					nx_mode = MODE_IDLE;
					nx_act  = '0;
				end
				OP_ONCE: begin
					nx_mode = MODE_ONCE;
					nx_dl   = time_q + TIME_W'(interval);
					nx_act  = act_bump;
				end
				OP_SEVERAL: begin
					nx_mode = MODE_SEVERAL;
					nx_rem  = repeat_count - 1'b1;
					nx_per  = interval;
					nx_dl   = time_q + TIME_W'(interval);
					nx_act  = act_bump;
				end
				OP_SET_PER: nx_per = interval;
				OP_ENABLE:  nx_act = ACT_W'(1);
				OP_DISABLE: nx_act = '0;
				OP_RESYNC:  nx_dl  = time_q;
				default:    we     = 1'b0;
			endcase
		end else if (cmd.scan_en && hit) begin
			we    = 1'b1;
			nx_dl = rd_dl + TIME_W'(rd_per);
			if (raise) begin
				case (rd_mode)
					MODE_ONCE: nx_act = rd_act - 1'b1;
					MODE_SEVERAL: begin
						if (rd_rem != '0) begin
							nx_rem = rd_rem - 1'b1;
						end else begin
							nx_act = '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_TIMERS; i++) begin
				mode_q[i] <= MODE_IDLE;
				act_q[i]  <= '0;
				dl_q[i]   <= '0;
				per_q[i]  <= '0;
				rem_q[i]  <= '0;
			end
		end else if (we) begin
			mode_q[sel] <= nx_mode;
			act_q[sel]  <= nx_act;
			dl_q[sel]   <= nx_dl;
			per_q[sel]  <= nx_per;
			rem_q[sel]  <= nx_rem;
		end
	end

	// a held fire is passed on when a later one shows up or at scan end
	assign out_load = cmd.flush || (cmd.scan_en && report && pend_v_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			idx_q    <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.accept_tick) begin
				time_q <= time_q + 1'b1;
				idx_q  <= '0;
				cnt_q  <= '0;
			end
			if (cmd.scan_en) begin
				idx_q <= idx_q + 1'b1;
				if (report) begin
					cnt_q    <= cnt_q + 1'b1;
					pend_v_q <= 1'b1;
				end
			end
			if (cmd.flush) begin
				pend_v_q <= 1'b0;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_en && report) begin
			pend_ch_q <= idx_q;
		end
		if (out_load) begin
			out_ch_q   <= CH_W'(pend_ch_q);
			out_last_q <= cmd.flush;
		end
	end

	assign out_valid     = out_v_q;
	assign fired_channel = out_ch_q;
	assign last          = out_last_q;

	assign sts.is_tick  = opcode == OP_TICK;
	assign sts.fire     = report;
	assign sts.pend_v   = pend_v_q;
	assign sts.out_free = out_free;
	assign sts.idx_last = idx_q == IDX_W'(NUM_TIMERS - 1);

endmodule

FILE: hw/rtl/mct_ctrl.sv
module mct_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mct_pkg::mct_sts_t sts,
	output mct_pkg::mct_cmd_t cmd
);
	import mct_pkg::*;

	ctrl_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (sts.is_tick) begin
						cmd.accept_tick = 1'b1;
						state_nx        = ST_SCAN;
					end else begin
						cmd.accept_cmd = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				// hold the channel when a new fire needs the full output slot
				if (!(sts.fire && sts.pend_v && !sts.out_free)) begin
					cmd.scan_en = 1'b1;
					if (sts.idx_last) begin
						state_nx = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_v) begin
					state_nx = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_nx  = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/multi_channel_interval_timer_top.sv
// channel | signals                                        | role
// in      | in_valid in_ready opcode channel interval      | command or tick item
//         | offset repeat_count                            |
// out     | out_valid out_ready fired_channel last         | one fire event per item
//
// a command item is applied at its accept edge and leaves the input open
// a tick item: the accept edge bumps the time, then one channel per cycle
// is checked and updated through the single shared read/modify/write port
// of the timer bank while the scan is not held, then a closing step hands
// any held fire event out with last set
// a full output register holds the scan on a channel that fires while a
// fire event is already held, and delays the closing step
// arst_n clears time, all timer entries and the handshake state at once
module multi_channel_interval_timer_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [mct_pkg::OP_W-1:0]  opcode,
	input  logic [mct_pkg::CH_W-1:0]  channel,
	input  logic [mct_pkg::PER_W-1:0] interval,
	input  logic [mct_pkg::PER_W-1:0] offset,
	input  logic [mct_pkg::REM_W-1:0] repeat_count,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [mct_pkg::CH_W-1:0]  fired_channel,
	output logic                      last
);
	import mct_pkg::*;

	// controller / datapath link
	mct_cmd_t cmd;
	mct_sts_t sts;

	// sequencer: idle, channel scan, final hand-off
	mct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// timer bank, time counter, held fire and output register
	mct_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.channel       (channel),
		.interval      (interval),
		.offset        (offset),
		.repeat_count  (repeat_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fired_channel (fired_channel),
		.last          (last)
	);

	// a tick item always starts a scan, so no item follows right behind it
	a_tick_blocks : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode == OP_TICK |=> !in_ready)
		else $error("input taken right after a tick item");

	// a command item never leaves the input side closed
	a_cmd_single : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && opcode != OP_TICK |=> in_ready)
		else $error("command item stalled the input side");

	// a scan step never drops a held fire while the output slot is still full
	a_no_overrun : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_en && sts.fire && sts.pend_v |-> sts.out_free)
		else $error("fire event overran the output register");

endmodule
